// File: hdl/assert_macros.svh
// Assertion macros shared by the checker module.
// Depends on nothing; each file that asserts includes this one.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// A condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// A condition that holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/vprb_pkg.sv
// Types and constants of the variable packet ring buffer.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps
package vprb_pkg;
  localparam int RING_BYTES   = 4096;
  localparam int HEADER_BYTES = 8;
  localparam int MAX_VECTORS  = 16;
  localparam int MEM_AW       = $clog2(RING_BYTES);
  localparam int VEC_AW       = $clog2(MAX_VECTORS);

  localparam logic [1:0] FUNC_RESERVE = 2'd0;
  localparam logic [1:0] FUNC_COMMIT  = 2'd1;
  localparam logic [1:0] FUNC_PEEK    = 2'd2;
  localparam logic [1:0] FUNC_RELEASE = 2'd3;

  localparam logic [1:0] KIND_RESERVE = 2'd0;
  localparam logic [1:0] KIND_VECTOR  = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_ACK     = 2'd3;

  localparam logic [1:0] CMD_PACKET = 2'd1;
  localparam logic [1:0] CMD_SKIP   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] length;
    logic [4:0]  max_vectors;
    logic [12:0] new_head;
  } vprb_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] offset;
    logic [12:0] length_res;
    logic        last;
  } vprb_out_t;
endpackage

// File: hdl/variable_packet_ring_buffer.sv
// Variable packet ring buffer controller: positions, header memory and peek walker.
// Depends on vprb_pkg.
`timescale 1ns / 1ps
// Usage. Commands arrive as beats on the in_ channel (valid/ready) and every
// command yields one or more result beats on the out_ channel, the final one
// marked by last. Reserve, commit and release give one beat; peek gives one
// beat per packet vector found followed by a peek end beat.
// The block works on one command at a time. A single-beat command passes
// through a state that forms the ring size, one for the operation and one
// that loads the output register; a reserve that wraps the tail repeats the
// operation state. A peek walks each header through a check state and a read
// state, since each header is one read of the header memory with a registered
// read port, and then gives one beat per cycle while the receiver does not stall.
// Results leave through an output register, so a stalled receiver simply
// holds the current beat; the block waits for that register to drain before
// issuing the next one.
// After reset the block runs a clearing pass over all 4096 header entries,
// one per cycle, during which in_ready stays low. Configuration writes on the
// APB port are accepted at any time and should only be made while idle.
module variable_packet_ring_buffer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vprb_pkg::vprb_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vprb_pkg::vprb_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import vprb_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SIZE   = 4'd2;
  localparam logic [3:0] S_RES    = 4'd3;
  localparam logic [3:0] S_COMMIT = 4'd4;
  localparam logic [3:0] S_REL    = 4'd5;
  localparam logic [3:0] S_PKSET  = 4'd6;
  localparam logic [3:0] S_PKW    = 4'd7;
  localparam logic [3:0] S_PKR    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  localparam logic [12:0] HDR13   = 13'(HEADER_BYTES);
  localparam logic [12:0] RING13  = 13'(RING_BYTES);
  localparam logic [4:0]  MAXV5   = 5'(MAX_VECTORS);

  // Configuration and positions.
  logic [11:0] max_payload_r;
  logic [12:0] slot_count_r;
  logic [12:0] rd_r, wr_r, size_r;
  logic [3:0]  state_r;
  logic [MEM_AW-1:0] clr_r;

  // Latched command.
  logic [1:0]  func_r;
  logic [12:0] len_r, head_arg_r;
  logic [4:0]  cap_r;

  // Walker and result bookkeeping.
  logic [12:0] ch_r, limit_r;
  logic        phase_r;
  logic [4:0]  n_r, e_r;
  logic [12:0] vo_r [MAX_VECTORS];
  logic [12:0] vl_r [MAX_VECTORS];
  logic [1:0]  end_kind_r;
  logic [12:0] end_off_r, end_len_r;
  logic        out_valid_r;
  vprb_out_t   out_r;

  // Header memory, one entry per ring byte where a header may start.
  logic [14:0] hdr_mem [RING_BYTES];
  logic [14:0] hdr_rd_r;
  logic        oob_r;
  logic        mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [14:0] mem_wdata;

  logic [25:0] prod;
  logic [12:0] packet, res_ws, res_ws2;
  logic        res_wrap_side;
  logic [14:0] commit_t;
  logic [14:0] hdr;
  logic [13:0] need;
  logic [12:0] room;
  logic        pk_fin, pk_bad, pk_push;
  logic [12:0] pk_pos;
  logic        slot_free;
  logic        cfg_wr;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign prdata    = paddr[2] ? {19'd0, slot_count_r} : {20'd0, max_payload_r};
  assign slot_free = !out_valid_r || out_ready;

  assign prod   = ({1'b0, max_payload_r} + HDR13) * slot_count_r;
  assign packet = {1'b0, max_payload_r} + HDR13;

  // Reserve: free space up to the ring end when the tail is at or past the
  // head, else the gap below the head less one byte.
  assign res_wrap_side = (rd_r <= wr_r);
  assign res_ws  = (wr_r < size_r) ? size_r - wr_r : 13'd0;
  assign res_ws2 = rd_r - wr_r - 13'd1;

  assign commit_t = 15'(wr_r) + 15'(HDR13) + 15'(len_r);

  assign hdr  = oob_r ? 15'd0 : hdr_rd_r;
  assign need = 14'(HDR13) + 14'(hdr[12:0]);
  assign room = limit_r - ch_r;

  // Walker decisions for the current state.
  always_comb begin
    pk_fin  = 1'b0;
    pk_bad  = 1'b0;
    pk_push = 1'b0;
    pk_pos  = ch_r;
    case (state_r)
      S_PKW: begin
        if (ch_r >= limit_r) begin
          pk_fin = 1'b1;
        end else if (room < HDR13) begin
          pk_fin = 1'b1;
          pk_pos = limit_r;
        end
      end
      S_PKR: begin
        if (hdr[14:13] == CMD_SKIP) begin
          pk_fin = 1'b1;
          pk_pos = limit_r;
        end else if (hdr[14:13] != CMD_PACKET) begin
          pk_bad = 1'b1;
        end else if (14'(room) < need) begin
          pk_bad = 1'b1;
        end else if (n_r >= cap_r) begin
          pk_fin = 1'b1;
        end else begin
          pk_push = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_r[MEM_AW-1:0];
    mem_wdata = 15'd0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      S_RES: begin
        if (res_wrap_side && res_ws < packet && res_ws >= HDR13) begin
          mem_we    = 1'b1;
          mem_wdata = {CMD_SKIP, 13'd0};
        end
      end
      S_COMMIT: begin
        if (len_r != 13'd0 && wr_r < RING13) begin
          mem_we    = 1'b1;
          mem_wdata = {CMD_PACKET, len_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[mem_waddr] <= mem_wdata;
    end
    hdr_rd_r <= hdr_mem[ch_r[MEM_AW-1:0]];
    oob_r    <= (ch_r >= RING13);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      rd_r          <= '0;
      wr_r          <= '0;
      max_payload_r <= 12'd248;
      slot_count_r  <= 13'd16;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2]) begin
          slot_count_r <= pwdata[12:0];
        end else begin
          max_payload_r <= pwdata[11:0];
        end
      end
      // Outside the emit state a taken beat simply empties the output register.
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == MEM_AW'(RING_BYTES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r     <= in_data.func;
            len_r      <= in_data.length;
            head_arg_r <= in_data.new_head;
            cap_r      <= (in_data.max_vectors > MAXV5) ? MAXV5 : in_data.max_vectors;
            state_r    <= S_SIZE;
          end
        end
        S_SIZE: begin
          size_r    <= (prod > 26'(RING_BYTES)) ? RING13 : prod[12:0];
          n_r       <= '0;
          e_r       <= '0;
          end_len_r <= '0;
          case (func_r)
            FUNC_RESERVE: state_r <= S_RES;
            FUNC_COMMIT:  state_r <= S_COMMIT;
            FUNC_PEEK:    state_r <= S_PKSET;
            default:      state_r <= S_REL;
          endcase
        end
        S_RES: begin
          end_kind_r <= KIND_RESERVE;
          if (res_wrap_side && res_ws < packet && rd_r != 13'd0) begin
            // Wrap the tail and try again from the ring start.
            wr_r <= '0;
          end else begin
            state_r <= S_EMIT;
            if (res_wrap_side && res_ws >= packet) begin
              end_off_r <= wr_r + HDR13;
              end_len_r <= res_ws - HDR13;
            end else if (!res_wrap_side && res_ws2 >= packet) begin
              end_off_r <= wr_r + HDR13;
              end_len_r <= res_ws2 - HDR13;
            end else begin
              end_off_r <= '0;
            end
          end
        end
        S_COMMIT: begin
          end_kind_r <= KIND_ACK;
          state_r    <= S_EMIT;
          if (len_r != 13'd0) begin
            if (commit_t >= 15'(size_r) && rd_r != 13'd0) begin
              wr_r      <= '0;
              end_off_r <= '0;
            end else if (commit_t > 15'h1FFF) begin
              wr_r      <= 13'h1FFF;
              end_off_r <= 13'h1FFF;
            end else begin
              wr_r      <= commit_t[12:0];
              end_off_r <= commit_t[12:0];
            end
          end else begin
            end_off_r <= wr_r;
          end
        end
        S_REL: begin
          rd_r       <= head_arg_r;
          end_kind_r <= KIND_ACK;
          end_off_r  <= head_arg_r;
          state_r    <= S_EMIT;
        end
        S_PKSET: begin
          ch_r       <= rd_r;
          end_kind_r <= KIND_END;
          if (rd_r <= wr_r) begin
            limit_r <= wr_r;
            phase_r <= 1'b1;
          end else begin
            limit_r <= size_r;
            phase_r <= 1'b0;
          end
          state_r <= S_PKW;
        end
        S_PKW, S_PKR: begin
          if (pk_bad) begin
            n_r       <= '0;
            end_off_r <= wr_r;
            state_r   <= S_EMIT;
          end else if (pk_fin) begin
            if (!phase_r && pk_pos == size_r) begin
              // First part ended at the ring end: continue from offset zero.
              ch_r    <= '0;
              limit_r <= wr_r;
              phase_r <= 1'b1;
              state_r <= S_PKW;
            end else begin
              end_off_r <= pk_pos;
              state_r   <= S_EMIT;
            end
          end else if (pk_push) begin
            vo_r[n_r[VEC_AW-1:0]] <= ch_r + HDR13;
            vl_r[n_r[VEC_AW-1:0]] <= hdr[12:0];
            n_r     <= n_r + 1'b1;
            ch_r    <= ch_r + need[12:0];
            state_r <= S_PKW;
          end else begin
            state_r <= S_PKR;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (e_r < n_r) begin
              out_r <= '{kind: KIND_VECTOR, offset: vo_r[e_r[VEC_AW-1:0]],
                         length_res: vl_r[e_r[VEC_AW-1:0]], last: 1'b0};
              e_r   <= e_r + 1'b1;
            end else begin
              out_r   <= '{kind: end_kind_r, offset: end_off_r,
                           length_res: end_len_r, last: 1'b1};
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/vprb_checker.sv
// Port-level checker for the variable packet ring buffer, bound to the top level.
// Depends on vprb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vprb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input vprb_pkg::vprb_out_t out_data,
  input logic                pready
);
  import vprb_pkg::*;

  `ASSERT_ALWAYS(a_pready_high, clk, rst_n, pready, "pready dropped")
  `ASSERT_NEXT(a_one_cmd, clk, rst_n, in_valid && in_ready, !in_ready, "second command taken at once")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled beat changed")
  `ASSERT_ALWAYS(a_last_kind, clk, rst_n, !out_valid || ((out_data.kind == KIND_VECTOR) != out_data.last), "last flag does not match kind")
endmodule

bind variable_packet_ring_buffer vprb_checker u_vprb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
